[hdl/sds_pkg.sv]
package sds_pkg;

  // Configuration register indexes.
  localparam logic CFG_DELIM_LENGTH = 1'b0;
  localparam logic CFG_DELIM_BYTES  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [3:0]  DELIM_LENGTH_RST = 4'd1;
  localparam logic [63:0] DELIM_BYTES_RST  = 64'd32;

  // Input command codes.
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_APPEND = 3'd1,
    OP_PASS   = 3'd2,
    OP_DRAIN  = 3'd3,
    OP_FINAL  = 3'd4
  } sds_op_t;

  typedef struct packed {
    sds_op_t op;
    logic    last;
  } sds_cmd_t;

  typedef struct packed {
    logic full;
    logic inc_full;
    logic empty;
    logic last_if_data;
    logic out_free;
  } sds_status_t;

endpackage

[hdl/sds_datapath.sv]
module sds_datapath
  import sds_pkg::*;
#(
  parameter int MAX_DELIM = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sds_cmd_t    cmd,
  output sds_status_t status,
  input  logic [7:0]  in_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_field_end,
  output logic        out_string_end,
  output logic        out_last_result
);

  localparam int CNT_W = $clog2(MAX_DELIM + 1);
  localparam int IDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam logic [3:0] MAX_LEN = 4'(MAX_DELIM);

  logic [3:0]       delim_length_r;
  logic [63:0]      delim_bytes_r;
  logic [7:0]       win_r   [MAX_DELIM];
  logic [7:0]       win_nxt [MAX_DELIM];
  logic [7:0]       win_shift [MAX_DELIM];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       eff4;
  logic [CNT_W-1:0] eff_len;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] drop_n;
  logic             match;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_fe_r, out_fe_nxt;
  logic             out_se_r, out_se_nxt;
  logic             out_last_r, out_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_length_r <= DELIM_LENGTH_RST;
      delim_bytes_r  <= DELIM_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELIM_LENGTH: delim_length_r <= cfg_data[3:0];
        CFG_DELIM_BYTES:  delim_bytes_r  <= cfg_data;
        default:          delim_bytes_r  <= delim_bytes_r;
      endcase
    end
  end

  // A zero length acts as one; anything above the window depth is clamped.
  always_comb begin
    eff4 = delim_length_r;
    if (eff4 == 4'd0) begin
      eff4 = 4'd1;
    end else if (eff4 > MAX_LEN) begin
      eff4 = MAX_LEN;
    end
    eff_len = eff4[CNT_W-1:0];
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if ((CNT_W'(i) < eff_len) && (win_r[i] != delim_bytes_r[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign rem     = match ? (cnt_r - eff_len) : (cnt_r - CNT_W'(1));

  assign status.full         = (cnt_r >= eff_len);
  assign status.inc_full     = (cnt_inc >= eff_len);
  assign status.empty        = (cnt_r == '0);
  assign status.last_if_data = (rem < eff_len);
  assign status.out_free     = !out_valid_r || !out_stall;

  assign drop_n = ((cmd.op == OP_PASS) && match) ? eff_len : CNT_W'(1);

  always_comb begin
    logic [CNT_W:0] src;
    for (int i = 0; i < MAX_DELIM; i++) begin
      src = (CNT_W + 1)'(i) + {1'b0, drop_n};
      if (src < (CNT_W + 1)'(MAX_DELIM)) begin
        win_shift[i] = win_r[src[IDX_W-1:0]];
      end else begin
        win_shift[i] = 8'd0;
      end
    end
  end

  always_comb begin
    win_nxt      = win_r;
    cnt_nxt      = cnt_r;
    out_byte_nxt = out_byte_r;
    out_fe_nxt   = out_fe_r;
    out_se_nxt   = out_se_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (cmd.op)
      OP_APPEND: begin
        win_nxt[cnt_r[IDX_W-1:0]] = in_byte;
        cnt_nxt = cnt_inc;
      end
      OP_PASS: begin
        win_nxt       = win_shift;
        cnt_nxt       = cnt_r - drop_n;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = match ? 8'd0 : win_r[0];
        out_fe_nxt    = match;
        out_se_nxt    = 1'b0;
        out_last_nxt  = cmd.last;
      end
      OP_DRAIN: begin
        win_nxt       = win_shift;
        cnt_nxt       = cnt_r - CNT_W'(1);
        out_valid_nxt = 1'b1;
        out_byte_nxt  = win_r[0];
        out_fe_nxt    = 1'b0;
        out_se_nxt    = 1'b0;
        out_last_nxt  = 1'b0;
      end
      OP_FINAL: begin
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = 8'd0;
        out_fe_nxt    = 1'b1;
        out_se_nxt    = 1'b1;
        out_last_nxt  = 1'b1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    out_byte_r <= out_byte_nxt;
    out_fe_r   <= out_fe_nxt;
    out_se_r   <= out_se_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_field_end   = out_fe_r;
  assign out_string_end  = out_se_r;
  assign out_last_result = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DELIM))
    else $error("window count exceeds depth");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FINAL |=> cnt_r == '0 && out_valid_r && out_se_r && out_last_r)
    else $error("final field end did not clear window");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("pending result lost under stall");

endmodule

[hdl/sds_ctrl.sv]
module sds_ctrl
  import sds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_cmd,
  output logic        in_stall,
  output logic        cfg_ready,
  input  sds_status_t status,
  output sds_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_RESOLVE = 3'b010,
    ST_DRAIN   = 3'b100
  } sds_state_t;

  sds_state_t state_r, state_nxt;
  logic       flush_r, flush_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    cmd.op    = OP_NONE;
    cmd.last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_DATA) begin
            cmd.op = OP_APPEND;
            if (status.inc_full) begin
              state_nxt = ST_RESOLVE;
              flush_nxt = 1'b0;
            end
          end else begin
            state_nxt = ST_RESOLVE;
            flush_nxt = 1'b1;
          end
        end
      end
      ST_RESOLVE: begin
        if (!status.full) begin
          state_nxt = flush_r ? ST_DRAIN : ST_IDLE;
        end else if (status.out_free) begin
          cmd.op   = OP_PASS;
          cmd.last = !flush_r && status.last_if_data;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          if (!status.empty) begin
            cmd.op = OP_DRAIN;
          end else begin
            cmd.op    = OP_FINAL;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PASS || cmd.op == OP_DRAIN || cmd.op == OP_FINAL) |-> status.out_free)
    else $error("result issued into a busy output register");

  a_drain_short: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> !status.full)
    else $error("drain entered with a full window");

  a_drain_flush: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> flush_r)
    else $error("drain reached without an end-of-string transaction");

endmodule

[hdl/substring_delimiter_splitter_core.sv]
// Splits a byte stream into fields at each occurrence of a configured delimiter of
// 1 to MAX_DELIM bytes, matching leftmost and without overlap. Each result transaction
// carries either a field byte or a field-end mark; an end-of-string transaction flushes
// the pending bytes and closes with a field end flagged as string end, and the last
// result caused by an input transaction carries last_result. A data transaction that
// does not complete a delimiter-length window is taken with no result. One that does
// stalls the input while the single resolve sequencer produces its results into the
// output register, one result a cycle while the output does not stall. An
// end-of-string transaction is accepted, produces the resolve results, switches to
// draining, emits each remaining byte and closes with the final field end. Output
// stall holds back each result. Configuration writes are taken only while no
// transaction is in progress.
module substring_delimiter_splitter_core
  import sds_pkg::*;
#(
  parameter int MAX_DELIM = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte,

  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_field_end,
  output logic        out_string_end,
  output logic        out_last_result,

  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  sds_cmd_t    cmd;
  sds_status_t status;
  logic        cfg_we;

  // The controller only opens the configuration channel while idle.
  assign cfg_we = cfg_valid && cfg_ready;

  sds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the delimiter registers, the pending-byte window and the
  // output register that decouples the result channel from the sequencer.
  sds_datapath #(
    .MAX_DELIM (MAX_DELIM)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_byte         (in_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_field_end   (out_field_end),
    .out_string_end  (out_string_end),
    .out_last_result (out_last_result)
  );

endmodule

[sim/sds_split_checker.sv]
`timescale 1ns / 1ps
module sds_split_checker
  import sds_pkg::*;
#(
  parameter int MAX_DELIM = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_field_end,
  input  logic        out_string_end,
  input  logic        out_last_result,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,

  output int          mismatches,
  output int          outstanding,
  output int          items_taken,
  output int          pieces_taken,
  output int          fields_closed,
  output int          strings_closed
);

  typedef struct packed {
    logic [7:0] chr;
    logic       field_end;
    logic       string_end;
    logic       last_result;
  } piece_t;

  piece_t      pending_pieces[$];
  logic [7:0]  window [8];
  int unsigned window_fill;
  logic [3:0]  delim_len;
  logic [63:0] delim_chars;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void add_piece(input logic [7:0] chr, input logic fe, input logic se);
    piece_t p;
    p.chr = chr;
    p.field_end = fe;
    p.string_end = se;
    p.last_result = 1'b0;
    pending_pieces.push_back(p);
  endfunction

  function automatic void drop_oldest(input int unsigned n);
    int i;
    if (n > window_fill) n = window_fill;
    for (i = 0; i < 8; i++) window[i] = (i + n < 8) ? window[i + n] : 8'h00;
    window_fill -= n;
  endfunction

  function automatic bit front_is_delim(input int unsigned l);
    int i;
    for (i = 0; i < l; i++) begin
      if (window[i] != delim_chars[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Match or pass on the oldest bytes while a whole delimiter length is buffered.
  function automatic int resolve_window(input int unsigned l, input int k);
    while (window_fill >= l && k < 8) begin
      if (front_is_delim(l)) begin
        add_piece(8'h00, 1'b1, 1'b0);
        drop_oldest(l);
      end else begin
        add_piece(window[0], 1'b0, 1'b0);
        drop_oldest(1);
      end
      k++;
    end
    return k;
  endfunction

  function automatic void split_item(input logic cmd, input logic [7:0] chr);
    int unsigned l;
    int unsigned fill_now;
    int          k;
    int          i;
    piece_t      tail;
    l = (delim_len == 0) ? 1 : ((delim_len > MAX_DELIM) ? MAX_DELIM : delim_len);
    k = 0;
    if (cmd == CMD_DATA) begin
      if (window_fill >= 8) begin
        k = resolve_window(l, k);
        if (window_fill >= 8) drop_oldest(1);
      end
      window[window_fill % 8] = chr;
      window_fill++;
      k = resolve_window(l, k);
    end else begin
      k = resolve_window(l, k);
      fill_now = window_fill;
      for (i = 0; i < fill_now && k < 7; i++) begin
        add_piece(window[i], 1'b0, 1'b0);
        k++;
      end
      foreach (window[j]) window[j] = 8'h00;
      window_fill = 0;
      add_piece(8'h00, 1'b1, 1'b1);
      k++;
    end
    if (k > 0) begin
      tail = pending_pieces.pop_back();
      tail.last_result = 1'b1;
      pending_pieces.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    piece_t want;
    if (!rst_n) begin
      pending_pieces.delete();
      foreach (window[j]) window[j] = 8'h00;
      window_fill = 0;
      delim_len = DELIM_LENGTH_RST;
      delim_chars = DELIM_BYTES_RST;
      mismatches = 0;
      items_taken = 0;
      pieces_taken = 0;
      fields_closed = 0;
      strings_closed = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        pieces_taken++;
        if (out_field_end === 1'b1) fields_closed++;
        if (out_string_end === 1'b1) strings_closed++;
        if (pending_pieces.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = pending_pieces.pop_front();
          if (out_byte !== want.chr)
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.chr));
          if (out_field_end !== want.field_end)
            report_mismatch($sformatf("out_field_end %b, expected %b",
                                      out_field_end, want.field_end));
          if (out_string_end !== want.string_end)
            report_mismatch($sformatf("out_string_end %b, expected %b",
                                      out_string_end, want.string_end));
          if (out_last_result !== want.last_result)
            report_mismatch($sformatf("out_last_result %b, expected %b",
                                      out_last_result, want.last_result));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DELIM_LENGTH) delim_len = cfg_data[3:0];
        else delim_chars = cfg_data;
      end
      if (in_valid && !in_stall) begin
        items_taken++;
        split_item(in_cmd, in_byte);
      end
      outstanding <= pending_pieces.size();
    end
  end

endmodule

[sim/substring_delimiter_splitter_core_tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the substring delimiter splitter. All prediction and
// comparison lives in the checker instance; this module only drives the three
// channels, paces them according to the current idle pattern and decides pass or fail.
module substring_delimiter_splitter_core_tb;
  import sds_pkg::*;

  // The longest end-of-string transaction is still busy after its last result has been
  // predicted, and this wait also covers a data transaction that is still busy.
  localparam int DRAIN_CYCLES  = 24;
  // Length of the receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_cmd    = CMD_DATA;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = CFG_DELIM_LENGTH;
  logic [63:0] cfg_data  = '0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_field_end;
  logic        out_string_end;
  logic        out_last_result;
  logic        cfg_ready;

  int mismatches;
  int outstanding;
  int items_taken;
  int pieces_taken;
  int fields_closed;
  int strings_closed;

  // Pacing knobs, in percent of cycles, set per phase by the stimulus.
  int gap_pct   = 0;
  int stall_pct = 0;

  // The stimulus asks for a long receiver hold-off by bumping hold_requests; the
  // receiver process serves each request by counting the stall cycles itself.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // Delimiter currently programmed, mirrored here only to shape the text we send.
  logic [3:0]  cur_len   = DELIM_LENGTH_RST;
  logic [63:0] cur_delim = DELIM_BYTES_RST;
  int          settings_used = 0;

  substring_delimiter_splitter_core #(
    .MAX_DELIM(8)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_field_end  (out_field_end),
    .out_string_end (out_string_end),
    .out_last_result(out_last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  sds_split_checker #(
    .MAX_DELIM(8)
  ) split_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_field_end  (out_field_end),
    .out_string_end (out_string_end),
    .out_last_result(out_last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .items_taken    (items_taken),
    .pieces_taken   (pieces_taken),
    .fields_closed  (fields_closed),
    .strings_closed (strings_closed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side: random stall at the phase's rate, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct = 77;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct = 77;
      end
      default: begin
        gap_pct = 15;
        stall_pct = 15;
      end
    endcase
  endtask

  // Offers one input transaction and returns once it has been taken. Valid is left
  // high so that back-to-back transactions never lower and raise it in one step;
  // it drops when the next call decides to insert idle cycles, or in quiesce.
  task automatic send_item(input logic cmd, input logic [7:0] chr);
    int gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_byte  <= chr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The byte field is ignored on end of string, so it carries noise there.
  task automatic send_flush();
    send_item(CMD_FLUSH, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(CMD_DATA, s[i]);
  endtask

  // Stops offering, waits for every predicted result and then lets the block settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Both registers are written on every change; only call this while quiet.
  task automatic set_delimiter(input logic [3:0] len, input logic [63:0] chars);
    write_cfg(CFG_DELIM_LENGTH, {60'd0, len});
    write_cfg(CFG_DELIM_BYTES, chars);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_len = len;
    cur_delim = chars;
    settings_used++;
  endtask

  // Delimiters built mostly from two letters, so that partial and overlapping
  // matches such as "aab" inside "aaab" come up often.
  function automatic logic [63:0] random_delimiter();
    logic [63:0] d;
    int j;
    for (j = 0; j < 8; j++) begin
      if ($urandom_range(99) < 70) d[8*j +: 8] = 8'h61 + 8'($urandom_range(1));
      else d[8*j +: 8] = 8'($urandom_range(255));
    end
    return d;
  endfunction

  initial begin
    int phase;
    int sent;
    int eff_len;
    int open_len;
    int target_len;
    int j;
    logic [3:0] len_pick;
    logic [63:0] delim_pick;

    set_idle(IDLE_NONE);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset delimiter (a single space).
    // An empty string still produces one empty field.
    send_flush();
    send_text("a b");
    send_flush();
    quiesce();

    // A length of zero acts as one, and only the low delimiter byte is compared even
    // though every byte of the register is set. A zero byte is plain text.
    set_delimiter(4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h00);
    send_flush();
    quiesce();

    // An overlong length acts as eight: a full eight-byte match, then seven bytes
    // that stay buffered without any result.
    set_delimiter(4'd15, 64'h4847_4645_4443_4241);
    send_text("ABCDEFGH");
    send_text("ABCDEFG");
    quiesce();

    // Shorten the delimiter in the middle of the string: the next byte releases the
    // whole window at once, eight results from one transaction.
    set_delimiter(4'd1, 64'h0000_0000_0000_0041);
    send_text("A");
    send_flush();
    quiesce();

    // Random phases. Each one picks a delimiter setting and an idle pattern, then
    // sends strings of random length built mostly from delimiter characters. The
    // last string of a phase is often left open, so the next setting lands mid-string.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: len_pick = 4'd1;
        1: len_pick = 4'd8;
        2: len_pick = 4'd0;
        3: len_pick = 4'd15;
        6: len_pick = 4'd1;
        default: len_pick = 4'($urandom_range(15));
      endcase
      case (phase)
        4: delim_pick = 64'h0;
        5: delim_pick = 64'hFFFF_FFFF_FFFF_FFFF;
        default: delim_pick = random_delimiter();
      endcase
      set_delimiter(len_pick, delim_pick);
      set_idle(idle_mode_t'(phase % 4));
      eff_len = (cur_len == 0) ? 1 : ((cur_len > 8) ? 8 : int'(cur_len));

      // With a one-byte delimiter every data transaction yields a result, so holding
      // the receiver off here backs the block up until it stalls its input.
      if (phase == 6) hold_requests++;

      sent = 0;
      open_len = 0;
      target_len = $urandom_range(12);
      while (sent < PHASE_ITEMS) begin
        if (open_len >= target_len) begin
          send_flush();
          sent++;
          open_len = 0;
          target_len = $urandom_range(12);
        end else if ($urandom_range(99) < 20) begin
          for (j = 0; j < eff_len; j++) send_item(CMD_DATA, cur_delim[8*j +: 8]);
          sent += eff_len;
          open_len += eff_len;
        end else begin
          case ($urandom_range(3))
            0, 1: send_item(CMD_DATA, cur_delim[8*$urandom_range(eff_len - 1) +: 8]);
            2: send_item(CMD_DATA, 8'h61 + 8'($urandom_range(1)));
            default: send_item(CMD_DATA, 8'($urandom_range(255)));
          endcase
          sent++;
          open_len++;
        end
      end
      quiesce();
    end

    $display("Covered %0d input and %0d result transactions: %0d field ends in %0d strings.",
             items_taken, pieces_taken, fields_closed, strings_closed);
    $display("Used %0d delimiter settings, zero and overlong lengths, under four idle patterns.",
             settings_used);
    if (mismatches == 0 && outstanding == 0) begin
      $display("substring_delimiter_splitter_core regression: pass");
    end else begin
      $display("substring_delimiter_splitter_core regression: fail");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run of this stimulus.
  initial begin
    #8ms;
    $display("Timed out with %0d results still expected.", outstanding);
    $display("substring_delimiter_splitter_core regression: fail");
    $finish;
  end

endmodule
